@@ rtl/core/gps_pkg.sv @@
// Shared constants, types and tables for the Gaussian peak sum core.
`timescale 1ns / 1ps
package gps_pkg;

   localparam int MAX_PEAKS = 8;
   localparam int IDX_W = $clog2(MAX_PEAKS);
   localparam int CNT_W = 4;
   localparam int EXP_TERMS = 12;
   localparam int N_LIMIT = 40;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [33:0] KFW_Q32 = 34'd10113875081;
   localparam logic [64:0] DCUT_Q32 = 65'd20 << 32;

   // floor(2^48 / LN2_Q32); (e * RECIP_LN2) >> 32 is floor(e * 2^16 / LN2_Q32) or one less
   localparam logic [32:0] RECIP_LN2 = 33'((65'd1 << 48) / 65'(LN2_Q32));

   localparam int DIV_BITS = 35;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_LOAD = 6'd35;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] count;
      logic [31:0]          den;
      logic [31:0]          rem_init;
      logic [DIV_BITS-1:0]  bits;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quo;
   } div_rsp_type;

   // floor(2^32 / k) for the Taylor term divisors
   function automatic logic [32:0] term_recip(input logic [CNT_W-1:0] k);
      logic [32:0] r;
      unique case (k)
         4'd1:    r = 33'h1_0000_0000;
         4'd2:    r = 33'd2147483648;
         4'd3:    r = 33'd1431655765;
         4'd4:    r = 33'd1073741824;
         4'd5:    r = 33'd858993459;
         4'd6:    r = 33'd715827882;
         4'd7:    r = 33'd613566756;
         4'd8:    r = 33'd536870912;
         4'd9:    r = 33'd477218588;
         4'd10:   r = 33'd429496729;
         4'd11:   r = 33'd390451572;
         4'd12:   r = 33'd357913941;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/gps_mul.sv @@
// Shared 33x33 unsigned multiplier with registered product.
`timescale 1ns / 1ps
module gps_mul
   import gps_pkg::*;
(
   input  logic        clock,
   input  logic [32:0] mul_a,
   input  logic [32:0] mul_b,
   output logic [65:0] mul_p
);

   logic [65:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 66'(mul_a) * 66'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

@@ rtl/core/gps_div.sv @@
// Restoring divider, one quotient bit per cycle, used for the peak width reciprocal.
`timescale 1ns / 1ps
module gps_div
   import gps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [31:0]          rem_ff;
   logic [31:0]          den_ff;
   logic [DIV_BITS-1:0]  bits_ff;
   logic [DIV_BITS-1:0]  quo_ff;
   logic [32:0]          trial;
   logic                 ge;
   logic [31:0]          rem_in;

   assign trial  = {rem_ff, bits_ff[DIV_BITS-1]};
   assign ge     = trial >= {1'b0, den_ff};
   assign rem_in = ge ? 32'(trial - {1'b0, den_ff}) : trial[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= div_req.count;
            rem_ff  <= div_req.rem_init;
            bits_ff <= div_req.bits;
            den_ff  <= div_req.den;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= {quo_ff[DIV_BITS-2:0], ge};
            bits_ff <= bits_ff << 1;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");

endmodule

@@ rtl/core/gaussian_peak_sum_core.sv @@
// Top level: peak table, evaluation sequencer and result register.
// A load beat writes one peak; with a nonzero width it stays busy for the
// bit-serial reciprocal (35 divider steps), with zero width it completes at once.
// An evaluate beat steps through the first active_peaks entries; an entry ends
// early if its width is zero, if the peak lies beyond the cutoff or if its
// exponent underflows, and otherwise runs on the shared 33x33 multiplier
// (reciprocal exponent reduction, then four states per Taylor term over
// twelve terms). busy is high throughout;
// the result appears for one cycle on rsp_valid and must be taken then.
`timescale 1ns / 1ps
module gaussian_peak_sum_core
   import gps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [2:0]  req_peak_index,
   input  logic [31:0] req_peak_height,
   input  logic [31:0] req_peak_centroid,
   input  logic [30:0] req_peak_width,
   input  logic [31:0] req_sample_x,
   input  logic        req_last_point,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_sum_value,
   output logic        rsp_result_last,
   output logic        rsp_saturated
);

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_SEL, S_MAG, S_CUT, S_SQ, S_EXP, S_NEST, S_NRED,
      S_TMUL, S_TRED, S_TREC, S_TFIX, S_SHIFT, S_HMUL, S_HACC, S_DONE
   } state_type;

   state_type state_ff;

   logic [31:0] height_ff [MAX_PEAKS];
   logic [31:0] centroid_ff [MAX_PEAKS];
   logic [31:0] inv_ff [MAX_PEAKS];

   logic [CNT_W-1:0]  active_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  i_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [31:0]       x_ff;
   logic              last_ff;
   logic signed [35:0] sum_ff;
   logic [20:0]       dq_ff;
   logic [24:0]       e_ff;
   logic [5:0]        n_ff;
   logic [31:0]       r_ff;
   logic [32:0]       term_ff;
   logic signed [35:0] acc_ff;
   logic [CNT_W-1:0]  k_ff;
   logic [31:0]       a_ff;
   logic [32:0]       ex_ff;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_sum_ff;
   logic              rsp_last_ff;
   logic              rsp_sat_ff;

   logic [32:0]  mul_a;
   logic [32:0]  mul_b;
   logic [65:0]  mul_p;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   logic [IDX_W-1:0] sel;
   logic [31:0]      c_sel;
   logic [31:0]      h_sel;
   logic [31:0]      inv_sel;
   logic [32:0]      diff;
   logic [32:0]      mag;
   logic [32:0]      hm;
   logic [64:0]      prod;
   logic [24:0]      e_val;
   logic [9:0]       n_est;
   logic [40:0]      r_raw;
   logic             r_ge;
   logic [31:0]      q_est;
   logic [35:0]      q_k;
   logic [35:0]      chk;
   logic [31:0]      q_fix;
   logic [31:0]      cm;
   logic             load_now;
   logic [31:0]      inv_sat;

   assign sel     = i_ff[IDX_W-1:0];
   assign c_sel   = centroid_ff[sel];
   assign h_sel   = height_ff[sel];
   assign inv_sel = inv_ff[sel];
   assign diff    = {x_ff[31], x_ff} - {c_sel[31], c_sel};
   assign mag     = diff[32] ? 33'(-diff) : diff;
   assign hm      = h_sel[31] ? 33'(-{h_sel[31], h_sel}) : {1'b0, h_sel};
   assign prod    = mul_p[64:0];
   assign e_val   = 25'((mul_p[41:0] + 42'h1_0000) >> 17);
   assign n_est   = mul_p[41:32];
   assign r_raw   = {e_ff, 16'b0} - mul_p[40:0];
   assign r_ge    = r_raw >= 41'(LN2_Q32);
   assign q_est   = mul_p[63:32];
   assign q_k     = ({4'b0, q_est} & {36{k_ff[0]}})
                  + ({3'b0, q_est, 1'b0} & {36{k_ff[1]}})
                  + ({2'b0, q_est, 2'b0} & {36{k_ff[2]}})
                  + ({1'b0, q_est, 3'b0} & {36{k_ff[3]}});
   assign chk     = {4'b0, a_ff} - q_k;
   assign q_fix   = q_est + 32'(chk >= 36'(k_ff));
   assign cm      = 32'((mul_p[63:0] + 64'h8000_0000) >> 32);
   assign load_now = (state_ff == S_IDLE) && start && !req_type;
   assign inv_sat = (div_rsp.quo[DIV_BITS-1:32] != '0) ? 32'hFFFF_FFFF : div_rsp.quo[31:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MAG: begin
            mul_a = mag;
            mul_b = {1'b0, inv_sel};
         end
         S_SQ: begin
            mul_a = 33'(dq_ff);
            mul_b = 33'(dq_ff);
         end
         S_EXP: begin
            mul_a = 33'(e_val);
            mul_b = RECIP_LN2;
         end
         S_NEST: begin
            mul_a = 33'(n_est);
            mul_b = {1'b0, LN2_Q32};
         end
         S_TMUL: begin
            mul_a = term_ff;
            mul_b = {1'b0, r_ff};
         end
         S_TREC: begin
            mul_a = {1'b0, a_ff};
            mul_b = term_recip(k_ff);
         end
         S_HMUL: begin
            mul_a = hm;
            mul_b = ex_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_req.start    = load_now && (req_peak_width != '0);
      div_req.count    = DIV_STEPS_LOAD;
      div_req.den      = {1'b0, req_peak_width};
      div_req.rem_init = '0;
      div_req.bits     = DIV_BITS'(KFW_Q32) + DIV_BITS'(req_peak_width >> 1);
   end

   gps_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   gps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (load_now) begin
         height_ff[req_peak_index]   <= req_peak_height;
         centroid_ff[req_peak_index] <= req_peak_centroid;
         if (req_peak_width == '0) begin
            inv_ff[req_peak_index] <= '0;
         end
      end
      if ((state_ff == S_LOAD) && div_rsp.done) begin
         inv_ff[idx_ff] <= inv_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (!req_type) begin
                     idx_ff <= req_peak_index;
                     if (req_peak_width != '0) begin
                        state_ff <= S_LOAD;
                     end
                  end else begin
                     x_ff     <= req_sample_x;
                     last_ff  <= req_last_point;
                     sum_ff   <= '0;
                     i_ff     <= '0;
                     count_ff <= (active_ff > CNT_W'(MAX_PEAKS)) ? CNT_W'(MAX_PEAKS)
                                                                 : active_ff;
                     state_ff <= S_SEL;
                  end
               end
            end
            S_LOAD: begin
               if (div_rsp.done) begin
                  state_ff <= S_IDLE;
               end
            end
            S_SEL: begin
               if (i_ff == count_ff) begin
                  state_ff <= S_DONE;
               end else if (inv_sel == '0) begin
                  i_ff <= i_ff + 1'b1;
               end else begin
                  state_ff <= S_MAG;
               end
            end
            S_MAG: state_ff <= S_CUT;
            S_CUT: begin
               if (prod > DCUT_Q32) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SEL;
               end else begin
                  dq_ff    <= 21'((prod + 65'h8000) >> 16);
                  state_ff <= S_SQ;
               end
            end
            S_SQ:  state_ff <= S_EXP;
            S_EXP: begin
               e_ff     <= e_val;
               state_ff <= S_NEST;
            end
            S_NEST: begin
               if (n_est >= 10'(N_LIMIT)) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SEL;
               end else begin
                  n_ff     <= n_est[5:0];
                  state_ff <= S_NRED;
               end
            end
            S_NRED: begin
               if (r_ge && (n_ff == 6'(N_LIMIT - 1))) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SEL;
               end else begin
                  if (r_ge) begin
                     n_ff <= n_ff + 1'b1;
                     r_ff <= 32'(r_raw - 41'(LN2_Q32));
                  end else begin
                     r_ff <= r_raw[31:0];
                  end
                  term_ff  <= 33'h1_0000_0000;
                  acc_ff   <= 36'sh1_0000_0000;
                  k_ff     <= CNT_W'(1);
                  state_ff <= S_TMUL;
               end
            end
            S_TMUL: state_ff <= S_TRED;
            S_TRED: begin
               a_ff     <= mul_p[63:32];
               state_ff <= S_TREC;
            end
            S_TREC: state_ff <= S_TFIX;
            S_TFIX: begin
               term_ff <= {1'b0, q_fix};
               if (k_ff[0]) begin
                  acc_ff <= acc_ff - $signed({4'b0, q_fix});
               end else begin
                  acc_ff <= acc_ff + $signed({4'b0, q_fix});
               end
               if (k_ff == CNT_W'(EXP_TERMS)) begin
                  state_ff <= S_SHIFT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_TMUL;
               end
            end
            S_SHIFT: begin
               ex_ff    <= acc_ff[35] ? '0 : (acc_ff[32:0] >> n_ff);
               state_ff <= S_HMUL;
            end
            S_HMUL: state_ff <= S_HACC;
            S_HACC: begin
               if (h_sel[31]) begin
                  sum_ff <= sum_ff - $signed({4'b0, cm});
               end else begin
                  sum_ff <= sum_ff + $signed({4'b0, cm});
               end
               i_ff     <= i_ff + 1'b1;
               state_ff <= S_SEL;
            end
            S_DONE: begin
               if (sum_ff > 36'sd2147483647) begin
                  rsp_sum_ff <= 32'h7FFF_FFFF;
                  rsp_sat_ff <= 1'b1;
               end else if (sum_ff < -36'sd2147483648) begin
                  rsp_sum_ff <= 32'h8000_0000;
                  rsp_sat_ff <= 1'b1;
               end else begin
                  rsp_sum_ff <= sum_ff[31:0];
                  rsp_sat_ff <= 1'b0;
               end
               rsp_last_ff  <= last_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sum_value   = rsp_sum_ff;
   assign rsp_result_last = rsp_last_ff;
   assign rsp_saturated   = rsp_sat_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat longer than one cycle");
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type) |=> busy) else $error("evaluate beat not taken");
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_type && (req_peak_width != '0)) |=> busy)
      else $error("load beat not taken");

endmodule
